// File: src/arp_cache_pkg.sv
// shared types and constants for the address resolution cache
`default_nettype none
package arp_cache_pkg;
    localparam int ENTRIES = 32;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int MAX_RESULTS = 32;
    localparam logic [31:0] EXPIRE_AGE_RESET = 32'd300;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_LOOKUP = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_TICK   = 3'd4,
        CMD_EXPIRE = 3'd5,
        CMD_DUMP   = 3'd6,
        CMD_BAD    = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_EMIT,
        ST_WAIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic            load;     // capture input beat, clear scan status
        logic            scan;     // evaluate slot idx for current command
        logic [IDX_W-1:0] idx;
        logic            finish;   // apply add/remove, build single result
        logic            emit;     // build dump result from slot idx
        logic            emit_last;
        logic            empty;    // dump with nothing to emit
        logic            out_take; // output register loaded
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        cmd_t            cmd;
        logic            slot_valid;
        logic            more_valid; // some valid slot above idx
        logic [6:0]      max_count;
    } sts_t;
endpackage
`default_nettype wire

// File: src/arp_cache_if.sv
// valid/ready channel interfaces for commands, results and configuration
`default_nettype none
interface arp_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
    logic        make_static;
    logic [6:0]  max_count;
    modport source (output valid, cmd, ip_addr, mac_addr, make_static, max_count,
                    input ready);
    modport sink (input valid, cmd, ip_addr, mac_addr, make_static, max_count,
                  output ready);
endinterface

interface arp_res_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [47:0] mac_out;
    logic [31:0] ip_out;
    logic        static_out;
    logic [31:0] stamp_out;
    logic        last;
    modport source (output valid, ok, mac_out, ip_out, static_out, stamp_out, last,
                    input ready);
    modport sink (input valid, ok, mac_out, ip_out, static_out, stamp_out, last,
                  output ready);
endinterface

interface arp_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// File: src/arp_cache_ctrl.sv
// command sequencer: walks the slots once per command and paces dump beats
`default_nettype none
module arp_cache_ctrl
    import arp_cache_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  wire sts_t sts,
    output ctl_t      ctl
);
    state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [6:0] sent_reg, sent_next;
    logic out_valid_reg, out_valid_next;
    logic [6:0] lim;
    logic at_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            sent_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            sent_reg <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign lim = (sts.max_count < 7'(MAX_RESULTS)) ? sts.max_count : 7'(MAX_RESULTS);
    assign at_end = (idx_reg == IDX_W'(ENTRIES - 1));
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        sent_next = sent_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctl = '0;
        ctl.idx = idx_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // the output register is separate, so a waiting result does not block
                in_ready = 1'b1;
                if (in_valid && in_ready)
                begin
                    ctl.load = 1'b1;
                    idx_next = '0;
                    sent_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.cmd == CMD_DUMP)
                begin
                    if (sent_reg >= lim)
                        state_next = ST_FINISH;
                    else if (sts.slot_valid)
                        state_next = ST_EMIT;
                    else if (at_end)
                        state_next = ST_FINISH;
                    else
                        idx_next = idx_reg + IDX_W'(1);
                end
                else
                begin
                    ctl.scan = 1'b1;
                    if (at_end)
                        state_next = ST_FINISH;
                    else
                        idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    ctl.emit = 1'b1;
                    ctl.out_take = 1'b1;
                    ctl.emit_last = (sent_reg + 7'd1 >= lim) || !sts.more_valid;
                    out_valid_next = 1'b1;
                    sent_next = sent_reg + 7'd1;
                    if (ctl.emit_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_FINISH:
            begin
                if (sts.cmd == CMD_DUMP && sent_reg != 7'd0)
                    state_next = ST_IDLE;
                else if (!out_valid_reg || out_ready)
                begin
                    ctl.finish = 1'b1;
                    ctl.empty = (sts.cmd == CMD_DUMP);
                    ctl.out_take = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// File: src/arp_cache_dp.sv
// entry store, scan status and result register
`default_nettype none
module arp_cache_dp
    import arp_cache_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ctl_t        ctl,
    output sts_t             sts,
    input  wire logic [2:0]  in_cmd,
    input  wire logic [31:0] in_ip,
    input  wire logic [47:0] in_mac,
    input  wire logic        in_static,
    input  wire logic [6:0]  in_max,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_data,
    output logic             ok,
    output logic [47:0]      mac_out,
    output logic [31:0]      ip_out,
    output logic             static_out,
    output logic [31:0]      stamp_out,
    output logic             last
);
    logic [ENTRIES-1:0] valid_reg, static_reg;
    logic [31:0] ip_mem [ENTRIES];
    logic [47:0] mac_mem [ENTRIES];
    logic [31:0] stamp_mem [ENTRIES];
    logic [31:0] now_reg, age_limit_reg;

    cmd_t cmd_reg;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;
    logic static_in_reg;
    logic [6:0] max_reg;

    logic hit_reg, free_found_reg;
    logic [IDX_W-1:0] hit_idx_reg, free_idx_reg;
    logic [47:0] hit_mac_reg;

    logic [IDX_W-1:0] i;
    logic cur_valid, cur_match;
    logic [31:0] age;
    logic [IDX_W-1:0] wr_idx;
    logic wr_en;
    logic [ENTRIES-1:0] above_mask;

    assign i = ctl.idx;
    assign cur_valid = valid_reg[i];
    assign cur_match = cur_valid && (ip_mem[i] == ip_reg);
    assign age = now_reg - stamp_mem[i];
    assign wr_en = ctl.finish && cmd_reg == CMD_ADD && (hit_reg || free_found_reg);
    assign wr_idx = hit_reg ? hit_idx_reg : free_idx_reg;
    // slots strictly above idx
    assign above_mask = {{(ENTRIES-1){1'b1}}, 1'b0} << i;

    assign sts.cmd = cmd_reg;
    assign sts.slot_valid = cur_valid;
    assign sts.more_valid = |(valid_reg & above_mask);
    assign sts.max_count = max_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd_t'(in_cmd);
            ip_reg <= in_ip;
            mac_reg <= in_mac;
            static_in_reg <= in_static;
            max_reg <= in_max;
        end
        if (wr_en)
        begin
            ip_mem[wr_idx] <= ip_reg;
            mac_mem[wr_idx] <= mac_reg;
            stamp_mem[wr_idx] <= now_reg;
        end
        if (ctl.scan && cur_match && !hit_reg)
        begin
            hit_idx_reg <= i;
            hit_mac_reg <= mac_mem[i];
        end
        if (ctl.scan && !cur_valid && !free_found_reg)
            free_idx_reg <= i;
        if (ctl.out_take)
        begin
            if (ctl.emit)
            begin
                ok <= 1'b1;
                mac_out <= mac_mem[i];
                ip_out <= ip_mem[i];
                static_out <= static_reg[i];
                stamp_out <= stamp_mem[i];
                last <= ctl.emit_last;
            end
            else
            begin
                mac_out <= '0;
                ip_out <= '0;
                static_out <= 1'b0;
                stamp_out <= '0;
                last <= 1'b1;
                case (cmd_reg)
                    CMD_ADD:    ok <= hit_reg || free_found_reg;
                    CMD_REMOVE: ok <= hit_reg && !static_reg[hit_idx_reg];
                    CMD_LOOKUP:
                    begin
                        ok <= hit_reg;
                        mac_out <= hit_reg ? hit_mac_reg : 48'd0;
                    end
                    CMD_CLEAR, CMD_TICK, CMD_EXPIRE: ok <= 1'b1;
                    default:    ok <= 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            static_reg <= '0;
            now_reg <= '0;
            age_limit_reg <= EXPIRE_AGE_RESET;
            hit_reg <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                age_limit_reg <= cfg_data;
            if (ctl.load)
            begin
                hit_reg <= 1'b0;
                free_found_reg <= 1'b0;
                if (cmd_t'(in_cmd) == CMD_TICK)
                    now_reg <= now_reg + 32'd1;
            end
            if (ctl.scan)
            begin
                if (cur_match)
                    hit_reg <= 1'b1;
                if (!cur_valid)
                    free_found_reg <= 1'b1;
                if (cmd_reg == CMD_CLEAR && !static_reg[i])
                    valid_reg[i] <= 1'b0;
                if (cmd_reg == CMD_EXPIRE && cur_valid && !static_reg[i]
                    && age > age_limit_reg)
                    valid_reg[i] <= 1'b0;
            end
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
                static_reg[wr_idx] <= static_in_reg;
            end
            if (ctl.finish && cmd_reg == CMD_REMOVE && hit_reg
                && !static_reg[hit_idx_reg])
                valid_reg[hit_idx_reg] <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// File: src/address_resolution_cache.sv
// top level of the address resolution cache
// Usage: commands enter on cmd_ch (valid/ready), one beat per command; results
// leave on res_ch, one beat per command except dump, which gives one beat per
// emitted entry with last set on the final beat. The user must write
// expire_age on cfg_ch only while the block is idle; the block does not
// enforce this. expire_age resets to 300. Every command other than dump
// walks all 32 slots once, one slot per cycle; a dump walks the slots in
// order, pausing at each emitted entry while the output register is busy,
// and stops after its final beat.
// Reset clears all valid and static marks and the tick counter at once; no
// clearing pass is needed. The result sits in an output register; when the
// receiver stalls the block holds it and, for a dump, pauses the slot walk.
// A new command is taken as soon as the previous one has finished its walk,
// even while its last result still waits.
`default_nettype none
module address_resolution_cache
    import arp_cache_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    arp_cmd_if.sink   cmd_ch,
    arp_res_if.source res_ch,
    arp_cfg_if.sink   cfg_ch
);
    ctl_t ctl;
    sts_t sts;

    assign cfg_ch.ready = 1'b1;

    arp_cache_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(cmd_ch.valid),
        .in_ready(cmd_ch.ready),
        .out_valid(res_ch.valid),
        .out_ready(res_ch.ready),
        .sts(sts),
        .ctl(ctl)
    );

    arp_cache_dp u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .ctl(ctl),
        .sts(sts),
        .in_cmd(cmd_ch.cmd),
        .in_ip(cmd_ch.ip_addr),
        .in_mac(cmd_ch.mac_addr),
        .in_static(cmd_ch.make_static),
        .in_max(cmd_ch.max_count),
        .cfg_we(cfg_ch.valid),
        .cfg_data(cfg_ch.data),
        .ok(res_ch.ok),
        .mac_out(res_ch.mac_out),
        .ip_out(res_ch.ip_out),
        .static_out(res_ch.static_out),
        .stamp_out(res_ch.stamp_out),
        .last(res_ch.last)
    );
endmodule
`default_nettype wire
